FILE: sv/mcrp_pkg.sv
// ----------------------------------------------------------------------------
// Motor command ramp profile package
// Shared widths, operation and phase codes, and the divider status type.
// ----------------------------------------------------------------------------
package mcrp_pkg;

  localparam int RAMP_TIME_BITS = 16;
  localparam int ELAPSED_W      = RAMP_TIME_BITS + 2;
  localparam int CMD_W          = 8;
  localparam int DELTA_W        = CMD_W + 1;
  localparam int PROD_W         = CMD_W + RAMP_TIME_BITS;
  localparam int CNT_W          = $clog2(PROD_W);
  localparam int QUOT_KEEP_W    = CMD_W + 1;

  localparam int OP_W           = 2;
  localparam int SPEED_W        = 7;
  localparam int RAMP_MS_W      = 16;
  localparam int PHASE_W        = 2;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 8;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
  localparam int                 SCALE_W     = 27;
  localparam int                 SCALE_SHIFT = 19;
  localparam logic [19:0]        SPEED_RECIP = 20'd665861;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  localparam logic [PHASE_W-1:0] PH_ACCEL = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HOLD  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DECEL = 2'd2;
  localparam logic [PHASE_W-1:0] PH_STOP  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_STOP_LEVEL  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LADDER_MODE = 1'd1;

  localparam logic [CMD_W-1:0] STOP_LEVEL_RESET = 8'd127;
  localparam logic [CMD_W-1:0] CMD_MAX          = 8'd255;

  typedef struct packed {
    logic done;
    logic rem_nonzero;
  } div_status_t;

endpackage

FILE: sv/motor_command_ramp_profile_core.sv
// ----------------------------------------------------------------------------
// Motor command ramp profile core
// Trapezoidal speed ramp generator for an 8-bit motor command byte.
// ----------------------------------------------------------------------------
// A set transaction loads the ramp registers and gives no result; a stop
// goes to ST_EMIT. A ramp-phase tick passes ST_PHASE, ST_MUL, ST_DIVGO,
// ST_DIV (the serial divider retires one quotient bit per cycle of the
// 24-bit product) and ST_FIN; hold and stopped ticks go from ST_PHASE to
// ST_EMIT, and a tick with no result returns to idle. The block accepts
// one transaction at a time, and a result waits in the output register; a
// new result is held back while that register is still full.
module motor_command_ramp_profile_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // direction [0], speed_percent [7:1], ramp_ms [23:8]
  input  logic [mcrp_pkg::IN_TDATA_W-1:0]       s_tdata,
  // operation [1:0]
  input  logic [mcrp_pkg::OP_W-1:0]             s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // motor_command [7:0], phase [9:8], zero [15:10]
  output logic [mcrp_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                  cfg_we,
  input  logic [mcrp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mcrp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import mcrp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t state;

  logic [CMD_W-1:0]          stop_level;
  logic                      ladder_mode;
  logic [ELAPSED_W-1:0]      elapsed;
  logic [CMD_W-1:0]          present;
  logic [CMD_W-1:0]          ramp_start;
  logic signed [DELTA_W-1:0] ramp_delta;
  logic                      moving_backwards;
  logic [RAMP_TIME_BITS-1:0] ramp_length;

  logic [ELAPSED_W-1:0]      e_cur;
  logic [CMD_W-1:0]          mag;
  logic                      neg;
  logic                      is_decel;
  logic [RAMP_TIME_BITS-1:0] x_val;
  logic [PROD_W-1:0]         prod;
  logic [CMD_W-1:0]          res_cmd;
  logic [PHASE_W-1:0]        res_phase;
  logic [CMD_W-1:0]          out_cmd;
  logic [PHASE_W-1:0]        out_phase;
  logic                      out_valid;

  logic                      in_fire;
  logic [OP_W-1:0]           op;
  logic                      in_dir;
  logic [SPEED_W-1:0]        in_speed;
  logic [RAMP_MS_W-1:0]      in_ramp;

  logic [SPEED_W-1:0]        spd_sat;
  logic [SCALE_W-1:0]        scale_prod;
  logic [CMD_W-1:0]          spd_scaled;
  logic signed [CMD_W+1:0]   target_raw;
  logic [CMD_W-1:0]          target;
  logic signed [DELTA_W-1:0] delta_set;
  logic signed [DELTA_W-1:0] delta_hold;
  logic [DELTA_W-1:0]        delta_abs;

  logic [ELAPSED_W-1:0]      t1;
  logic [ELAPSED_W-1:0]      t2;
  logic [ELAPSED_W-1:0]      t3;
  logic [ELAPSED_W-1:0]      e_dec;

  logic                      div_start;
  logic [PROD_W-1:0]         div_quot;
  div_status_t               div_stat;
  logic [QUOT_KEEP_W-1:0]    q_mag;
  logic signed [CMD_W+2:0]   q_signed;
  logic signed [CMD_W+2:0]   v_sum;
  logic [CMD_W-1:0]          lo;
  logic [CMD_W-1:0]          hi;
  logic [CMD_W-1:0]          v_clamp;
  logic                      out_free;

  assign op       = s_tuser;
  assign in_dir   = s_tdata[0];
  assign in_speed = s_tdata[SPEED_W:1];
  assign in_ramp  = s_tdata[IN_TDATA_W-1:SPEED_W+1];

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // Speed scaling by 127/100 through a reciprocal multiply.
  assign spd_sat    = (in_speed > SPEED_MAX) ? SPEED_MAX : in_speed;
  assign scale_prod = SCALE_W'(spd_sat) * SCALE_W'(SPEED_RECIP);
  assign spd_scaled = scale_prod[SCALE_SHIFT+CMD_W-1:SCALE_SHIFT];

  always_comb begin
    if (in_dir) begin
      target_raw = $signed({2'b00, stop_level}) - $signed({2'b00, spd_scaled});
    end else begin
      target_raw = $signed({2'b00, stop_level}) + $signed({2'b00, spd_scaled});
    end
    if (target_raw < 0) begin
      target = '0;
    end else if (target_raw > $signed({2'b00, CMD_MAX})) begin
      target = CMD_MAX;
    end else begin
      target = target_raw[CMD_W-1:0];
    end
  end

  assign delta_set  = $signed({1'b0, target}) - $signed({1'b0, present});
  assign delta_hold = $signed({1'b0, present}) - $signed({1'b0, stop_level});
  assign delta_abs  = ramp_delta[DELTA_W-1] ? DELTA_W'(-ramp_delta) : ramp_delta;

  assign t1    = ELAPSED_W'(ramp_length);
  assign t2    = t1 << 1;
  assign t3    = t2 + t1;
  assign e_dec = e_cur - t2;

  assign div_start = (state == ST_DIVGO);

  mcrp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (ramp_length),
    .quotient (div_quot),
    .status   (div_stat)
  );

  // Floor division of a signed numerator from the unsigned quotient.
  assign q_mag = div_quot[QUOT_KEEP_W-1:0];

  always_comb begin
    if (neg) begin
      q_signed = -$signed({2'b00, q_mag}) - $signed({10'd0, div_stat.rem_nonzero});
    end else begin
      q_signed = $signed({2'b00, q_mag});
    end
    v_sum = $signed({3'b000, ramp_start}) + q_signed;
    if (is_decel && !moving_backwards) begin
      lo = stop_level;
    end else begin
      lo = '0;
    end
    if (is_decel && moving_backwards) begin
      hi = stop_level;
    end else begin
      hi = CMD_MAX;
    end
    if (v_sum < $signed({3'b000, lo})) begin
      v_clamp = lo;
    end else if (v_sum > $signed({3'b000, hi})) begin
      v_clamp = hi;
    end else begin
      v_clamp = v_sum[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      stop_level       <= STOP_LEVEL_RESET;
      ladder_mode      <= 1'b1;
      elapsed          <= '0;
      present          <= STOP_LEVEL_RESET;
      ramp_start       <= STOP_LEVEL_RESET;
      ramp_delta       <= '0;
      moving_backwards <= 1'b0;
      ramp_length      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (m_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_STOP_LEVEL:  stop_level  <= cfg_data;
          REG_LADDER_MODE: ladder_mode <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (op)
              OP_SET: begin
                moving_backwards <= in_dir;
                ramp_delta       <= delta_set;
                ramp_start       <= present;
                ramp_length      <= RAMP_TIME_BITS'(in_ramp);
                elapsed          <= '0;
              end
              OP_STOP: begin
                present   <= stop_level;
                res_cmd   <= stop_level;
                res_phase <= PH_STOP;
                state     <= ST_EMIT;
              end
              OP_TICK: begin
                e_cur <= elapsed;
                if (elapsed != {ELAPSED_W{1'b1}}) begin
                  elapsed <= elapsed + 1'b1;
                end
                state <= ST_PHASE;
              end
              default: ;
            endcase
          end
        end
        ST_PHASE: begin
          if (e_cur < t1) begin
            mag      <= delta_abs[CMD_W-1:0];
            neg      <= ramp_delta[DELTA_W-1];
            x_val    <= e_cur[RAMP_TIME_BITS-1:0];
            is_decel <= 1'b0;
            state    <= ST_MUL;
          end else if (!ladder_mode) begin
            state <= ST_IDLE;
          end else if (e_cur < t2) begin
            ramp_delta <= delta_hold;
            ramp_start <= present;
            res_cmd    <= present;
            res_phase  <= PH_HOLD;
            state      <= ST_EMIT;
          end else if (e_cur < t3) begin
            mag      <= delta_abs[CMD_W-1:0];
            neg      <= !ramp_delta[DELTA_W-1] && (ramp_delta != '0);
            x_val    <= e_dec[RAMP_TIME_BITS-1:0];
            is_decel <= 1'b1;
            state    <= ST_MUL;
          end else begin
            present   <= stop_level;
            res_cmd   <= stop_level;
            res_phase <= PH_STOP;
            state     <= ST_EMIT;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(x_val);
          state <= ST_DIVGO;
        end
        ST_DIVGO: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          present   <= v_clamp;
          res_cmd   <= v_clamp;
          res_phase <= is_decel ? PH_DECEL : PH_ACCEL;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_cmd   <= res_cmd;
            out_phase <= res_phase;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W - CMD_W - PHASE_W){1'b0}}, out_phase, out_cmd};

endmodule

FILE: sv/mcrp_divider.sv
// ----------------------------------------------------------------------------
// Motor command ramp profile serial divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcrp_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [mcrp_pkg::PROD_W-1:0]          dividend,
  input  logic [mcrp_pkg::RAMP_TIME_BITS-1:0]  divisor,
  output logic [mcrp_pkg::PROD_W-1:0]          quotient,
  output mcrp_pkg::div_status_t                status
);
  import mcrp_pkg::*;

  logic [RAMP_TIME_BITS-1:0] rem;
  logic [PROD_W-1:0]         dq;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [RAMP_TIME_BITS:0]   trial;
  logic [RAMP_TIME_BITS:0]   diff;
  logic                      fits;

  assign trial = {rem, dq[PROD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = ~diff[RAMP_TIME_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dq   <= dividend;
      end else if (busy) begin
        rem <= fits ? diff[RAMP_TIME_BITS-1:0] : trial[RAMP_TIME_BITS-1:0];
        dq  <= {dq[PROD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient           = dq;
  assign status.done        = done;
  assign status.rem_nonzero = |rem;

endmodule

FILE: verif/motor_command_ramp_profile_core_tb.sv
// ----------------------------------------------------------------------------
// Motor command ramp profile core testbench
// Drives tick, set, stop and unused-code transactions into the ramp
// generator under several stop levels and both profile modes. Every input
// transaction is scored by a behavioral predictor of the ramp. Each output
// transaction is compared, field by field, with the oldest pending command.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module motor_command_ramp_profile_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcrp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam longint          ELAPSED_TOP = (longint'(1) << ELAPSED_W) - 1;
  localparam int              CYCLE_LIMIT = 1000000;
  localparam int              SETTLE_CYC  = 80;
  localparam int              PHASE_ITEMS = 230;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic                 dir;
    logic [SPEED_W-1:0]   speed;
    logic [RAMP_MS_W-1:0] ramp;
    bit                   drain_first;
  } ramp_req_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PHASE_W-1:0] ph;
  } drive_out_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]        s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  motor_command_ramp_profile_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state.
  longint     stop_lvl;
  bit         ladder_on;
  longint     tick_count;
  longint     cmd_now;
  longint     ramp_base;
  longint     ramp_span;
  bit         reverse_dir;
  longint     ramp_ticks;

  ramp_req_t  stim_q[$];
  drive_out_t cmd_due_q[$];
  ramp_req_t  cur_item;
  drive_out_t want;

  int         pushed_cnt;
  int         accepted_cnt;
  int         results_seen;
  int         err_count;
  int         cycle_cnt;
  int         phase_seen[4];
  int         gap_cnt;
  int         stall_cnt;
  bit         idle_on;
  bit         rx_idle_on;
  logic       in_taken;
  logic       out_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic ramp_req_t mk(logic [OP_W-1:0] op, logic dir,
                                   logic [SPEED_W-1:0] speed,
                                   logic [RAMP_MS_W-1:0] ramp);
    ramp_req_t r;
    r.op          = op;
    r.dir         = dir;
    r.speed       = speed;
    r.ramp        = ramp;
    r.drain_first = 1'b0;
    return r;
  endfunction

  // Builds a transaction of the given code with random payload fields.
  function automatic ramp_req_t mk_rand(logic [OP_W-1:0] op);
    return mk(op, 1'($urandom), SPEED_W'($urandom), RAMP_MS_W'($urandom));
  endfunction

  task automatic push_item(input ramp_req_t r);
    stim_q.push_back(r);
    pushed_cnt++;
  endtask

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    err_count++;
    if (err_count <= 30)
      $display("MISMATCH %s: expected %0d, got %0d (result %0d)",
               what, want_v, got_v, results_seen);
  endtask

  // Advances the ramp profile by one accepted transaction and queues the
  // command it is expected to produce, if any.
  task automatic advance_profile(input ramp_req_t r);
    longint     spd;
    longint     tgt;
    longint     e;
    longint     t;
    longint     v;
    drive_out_t res;
    bit         emit_res;
    emit_res = 1'b0;
    res.ph   = PH_STOP;
    case (r.op)
      OP_SET: begin
        spd = longint'(r.speed);
        if (spd > 100) spd = 100;
        spd = (spd * 127) / 100;
        reverse_dir = r.dir;
        tgt = r.dir ? stop_lvl - spd : stop_lvl + spd;
        tgt = clip(tgt, 0, 255);
        ramp_span  = tgt - cmd_now;
        ramp_base  = cmd_now;
        ramp_ticks = longint'(r.ramp);
        tick_count = 0;
      end
      OP_STOP: begin
        cmd_now  = stop_lvl;
        res.ph   = PH_STOP;
        emit_res = 1'b1;
      end
      OP_TICK: begin
        e = tick_count;
        t = ramp_ticks;
        if (tick_count < ELAPSED_TOP) tick_count++;
        if (e < t) begin
          v        = ramp_base + floor_quot(ramp_span * e, t);
          cmd_now  = clip(v, 0, 255);
          res.ph   = PH_ACCEL;
          emit_res = 1'b1;
        end else if (!ladder_on) begin
          emit_res = 1'b0;
        end else if (e < 2 * t) begin
          ramp_span = cmd_now - stop_lvl;
          ramp_base = cmd_now;
          res.ph    = PH_HOLD;
          emit_res  = 1'b1;
        end else if (e < 3 * t) begin
          v = ramp_base + floor_quot(-ramp_span * (e - 2 * t), t);
          cmd_now  = reverse_dir ? clip(v, 0, stop_lvl) : clip(v, stop_lvl, 255);
          res.ph   = PH_DECEL;
          emit_res = 1'b1;
        end else begin
          cmd_now  = stop_lvl;
          res.ph   = PH_STOP;
          emit_res = 1'b1;
        end
      end
      default: ;
    endcase
    if (emit_res) begin
      res.cmd = cmd_now[CMD_W-1:0];
      cmd_due_q.push_back(res);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_STOP_LEVEL) stop_lvl = longint'(val);
    else ladder_on = val[0];
  endtask

  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || cmd_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // One set followed by a run of ticks, mostly long enough to walk the
  // whole profile, sometimes cut short so the next set starts mid-ramp.
  task automatic queue_profile();
    ramp_req_t r;
    int        n;
    int        k;
    if ($urandom_range(0, 9) == 0) begin
      r = mk_rand(OP_W'($urandom_range(0, 3)));
      r.drain_first = ($urandom_range(0, 49) == 0);
      push_item(r);
      return;
    end
    r = mk_rand(OP_SET);
    case ($urandom_range(0, 3))
      0: r.speed = SPEED_W'($urandom_range(95, 127));
      1: r.speed = SPEED_W'($urandom_range(0, 12));
      default: ;
    endcase
    k = $urandom_range(0, 19);
    if (k == 0) r.ramp = RAMP_MS_W'($urandom);
    else if (k < 3) r.ramp = RAMP_MS_W'($urandom_range(0, 40));
    else r.ramp = RAMP_MS_W'($urandom_range(0, 6));
    r.drain_first = ($urandom_range(0, 99) == 0);
    push_item(r);
    if (r.ramp > 40) n = $urandom_range(0, 4);
    else n = 3 * r.ramp + $urandom_range(0, 3);
    if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 39);
      if (k == 0) push_item(mk_rand(OP_STOP));
      else if (k == 1) push_item(mk_rand(OP_UNUSED));
      push_item(mk_rand(OP_TICK));
    end
  endtask

  // Input side: presents queued transactions with random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          s_tvalid <= 1'b0;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain_first && cmd_due_q.size() != 0)) begin
          cur_item = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_item.ramp, cur_item.speed, cur_item.dir};
          s_tuser  <= cur_item.op;
          if ($urandom_range(0, 149) == 0) idle_on = !idle_on;
          gap_cnt = idle_on ? $urandom_range(0, 9) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: stalls a random number of cycles before each result.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
        stall_cnt = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        results_seen++;
        phase_seen[m_tdata[9:8]]++;
        if (cmd_due_q.size() == 0) begin
          report_mismatch("unexpected result", 0, int'(m_tdata));
        end else begin
          want = cmd_due_q.pop_front();
          if (m_tdata[7:0] !== want.cmd)
            report_mismatch("motor_command", int'(want.cmd), int'(m_tdata[7:0]));
          if (m_tdata[9:8] !== want.ph)
            report_mismatch("phase", int'(want.ph), int'(m_tdata[9:8]));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_profile(cur_item);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [CMD_W-1:0] lvl_set[8];
    bit               mode_set[8];
    ramp_req_t        r;
    int               goal;
    lvl_set  = '{8'd127, 8'd0, 8'd255, 8'd127, 8'd0, 8'd255, 8'd0, 8'd0};
    mode_set = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    lvl_set[6] = CMD_W'($urandom);
    lvl_set[7] = CMD_W'($urandom);

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_TICK;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_STOP_LEVEL;
    cfg_data   = '0;
    stop_lvl   = longint'(STOP_LEVEL_RESET);
    ladder_on  = 1'b1;
    tick_count = 0;
    cmd_now    = longint'(STOP_LEVEL_RESET);
    ramp_base  = longint'(STOP_LEVEL_RESET);
    ramp_span  = 0;
    reverse_dir = 1'b0;
    ramp_ticks = 0;
    gap_cnt    = 0;
    stall_cnt  = 0;
    idle_on    = 1'b1;
    rx_idle_on = 1'b1;
    cycle_cnt  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_STOP_LEVEL, STOP_LEVEL_RESET);
    write_reg(REG_LADDER_MODE, 8'd1);

    // Directed: a tick with no ramp, the unused code, a stop, then
    // profiles at saturated, zero and maximum-ramp settings, some cut short.
    push_item(mk(OP_TICK, 1'b0, 7'd0, 16'd0));
    push_item(mk(OP_UNUSED, 1'b1, 7'h7F, 16'hFFFF));
    push_item(mk(OP_STOP, 1'b0, 7'd0, 16'd0));
    push_item(mk(OP_SET, 1'b0, 7'd127, 16'd2));
    repeat (7) push_item(mk(OP_TICK, 1'b1, 7'h55, 16'hAAAA));
    push_item(mk(OP_SET, 1'b1, 7'd100, 16'd1));
    repeat (4) push_item(mk(OP_TICK, 1'b0, 7'h2A, 16'h5555));
    push_item(mk(OP_SET, 1'b0, 7'd0, 16'd0));
    push_item(mk(OP_TICK, 1'b0, 7'd0, 16'd0));
    push_item(mk(OP_SET, 1'b1, 7'd37, 16'hFFFF));
    repeat (2) push_item(mk(OP_TICK, 1'b0, 7'd0, 16'd0));
    r = mk(OP_STOP, 1'b1, 7'h7F, 16'hFFFF);
    r.drain_first = 1'b1;
    push_item(r);
    push_item(mk(OP_SET, 1'b0, 7'd64, 16'd3));
    repeat (2) push_item(mk(OP_TICK, 1'b0, 7'd0, 16'd0));
    push_item(mk(OP_SET, 1'b1, 7'd101, 16'd2));
    repeat (3) push_item(mk(OP_TICK, 1'b0, 7'd0, 16'd0));

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(REG_STOP_LEVEL, lvl_set[p]);
      write_reg(REG_LADDER_MODE, CFG_DATA_W'(mode_set[p]));
      goal = pushed_cnt + PHASE_ITEMS;
      while (pushed_cnt < goal) queue_profile();
    end
    wait_idle();

    $display("Covered %0d input transactions over 9 register settings, %0d results checked.",
             accepted_cnt, results_seen);
    $display("Results by phase: accel %0d, hold %0d, decel %0d, stopped %0d.",
             phase_seen[PH_ACCEL], phase_seen[PH_HOLD], phase_seen[PH_DECEL],
             phase_seen[PH_STOP]);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: motor_command_ramp_profile_core.f
sv/mcrp_pkg.sv
sv/mcrp_divider.sv
sv/motor_command_ramp_profile_core.sv
verif/motor_command_ramp_profile_core_tb.sv
